>>> hw/rtl/mrbr_pkg.sv
// ----------------------------------------------------------------------------
// mrbr_pkg
// Shared types and sizes for the multi-reader broadcast ring.
// ----------------------------------------------------------------------------
package mrbr_pkg;

	localparam int SLOTS     = 16;
	localparam int READERS   = 8;
	localparam int WORD_BITS = 32;

	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W  = $clog2(SLOTS + 1);
	localparam int RID_W  = (READERS > 1) ? $clog2(READERS) : 1;

	// fixed field widths of the command and result items
	localparam int OP_W  = 2;
	localparam int ID_W  = 3;
	localparam int ST_W  = 3;

	typedef enum logic [OP_W-1:0] {
		OP_SUBSCRIBE   = 2'd0,
		OP_UNSUBSCRIBE = 2'd1,
		OP_WRITE       = 2'd2,
		OP_READ        = 2'd3
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK          = 3'd0,
		ST_NO_ID       = 3'd1,
		ST_DROPPED     = 3'd2,
		ST_OVERWROTE   = 3'd3,
		ST_EMPTY       = 3'd4,
		ST_NOT_PENDING = 3'd5
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_EXEC = 1'b1
	} state_t;

	typedef struct packed {
		logic [OP_W-1:0]      op;
		logic [ID_W-1:0]      subscriber;
		logic [WORD_BITS-1:0] write_word;
	} cmd_t;

	typedef struct packed {
		logic [ST_W-1:0]      status;
		logic [ID_W-1:0]      given_id;
		logic [WORD_BITS-1:0] read_word;
	} result_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic execute;
	} ctl_t;

endpackage

>>> hw/rtl/mrbr_ram.sv
// ----------------------------------------------------------------------------
// mrbr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mrbr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> hw/rtl/mrbr_ctrl.sv
// ----------------------------------------------------------------------------
// mrbr_ctrl
// Two-state sequencer: take an item, execute it, strobe the result.
// ----------------------------------------------------------------------------
module mrbr_ctrl
	import mrbr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	output logic done,
	output ctl_t ctl
);

	state_t state_q, state_d;
	logic   done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= ctl.execute;
		end
	end

	always_comb begin
		state_d     = state_q;
		ctl.capture = 1'b0;
		ctl.execute = 1'b0;
		busy        = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					ctl.capture = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				busy        = 1'b1;
				ctl.execute = 1'b1;
				state_d     = S_IDLE;
			end
		endcase
	end

	assign done = done_q;

	// busy drops again after every execute state
	a_busy_single: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy) else $error("busy held for two cycles");

	// a strobe only ever follows an execute cycle
	a_done_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.execute |=> done) else $error("no result after execute");

endmodule

>>> hw/rtl/mrbr_dp.sv
// ----------------------------------------------------------------------------
// mrbr_dp
// Ring state, pending masks, reader pointers and the slot word RAM.
// ----------------------------------------------------------------------------
module mrbr_dp
	import mrbr_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  ctl_t    ctl,
	input  cmd_t    cmd,
	output result_t result
);

	// captured item
	op_t                  op_q;
	logic [ID_W-1:0]      id_q;
	logic [WORD_BITS-1:0] word_q;
	logic [SLOT_W-1:0]    pos_q;

	// ring state
	logic [READERS-1:0] active_q, active_d;
	logic [READERS-1:0] pending_q [SLOTS];
	logic [READERS-1:0] pending_d [SLOTS];
	logic [SLOT_W-1:0]  oldest_q, oldest_d;
	logic [CNT_W-1:0]   count_q, count_d;
	logic [SLOT_W-1:0]  rdidx_q [READERS];

	logic               rdidx_we;
	logic [RID_W-1:0]   rdidx_wa;
	logic [SLOT_W-1:0]  rdidx_wd;

	logic                 ram_we;
	logic [SLOT_W-1:0]    ram_raddr;
	logic [WORD_BITS-1:0] ram_rdata;

	logic [SLOT_W-1:0]  end_idx;
	logic [RID_W-1:0]   id_r;
	logic               id_ok;
	logic [RID_W-1:0]   free_id;
	logic               free_found;
	logic [SLOTS-1:0]   in_range;
	logic [READERS-1:0] pend_left;
	result_t            res_d, res_q;

	// (a + b) mod SLOTS, both below SLOTS+1
	function automatic logic [SLOT_W-1:0] slot_add(logic [SLOT_W-1:0] a,
			logic [CNT_W-1:0] b);
		logic [CNT_W:0] s;
		s = (CNT_W+1)'(a) + (CNT_W+1)'(b);
		if (s >= (CNT_W+1)'(SLOTS)) begin
			s = s - (CNT_W+1)'(SLOTS);
		end
		return s[SLOT_W-1:0];
	endfunction

	assign id_r      = id_q[RID_W-1:0];
	assign id_ok     = ({{(32-ID_W){1'b0}}, id_q} < 32'(READERS));
	assign end_idx   = slot_add(oldest_q, count_q);
	assign ram_raddr = rdidx_q[cmd.subscriber[RID_W-1:0]];
	assign pend_left = pending_q[pos_q] & ~(READERS'(1) << id_r);

	// lowest clear bit of the active mask
	always_comb begin
		free_id    = '0;
		free_found = 1'b0;
		for (int i = READERS - 1; i >= 0; i--) begin
			if (!active_q[i]) begin
				free_id    = RID_W'(i);
				free_found = 1'b1;
			end
		end
	end

	// slot lies within the held window
	always_comb begin
		logic [SLOT_W:0] d;
		for (int i = 0; i < SLOTS; i++) begin
			d = (SLOT_W+1)'(i) - (SLOT_W+1)'(oldest_q);
			if (d[SLOT_W]) begin
				d = d + (SLOT_W+1)'(SLOTS);
			end
			in_range[i] = (CNT_W'(d[SLOT_W-1:0]) < count_q);
		end
	end

	always_comb begin
		active_d  = active_q;
		pending_d = pending_q;
		oldest_d  = oldest_q;
		count_d   = count_q;
		rdidx_we  = 1'b0;
		rdidx_wa  = id_r;
		rdidx_wd  = oldest_q;
		ram_we    = 1'b0;
		res_d     = '0;
		res_d.status = ST_OK;
		unique case (op_q)
			OP_SUBSCRIBE: begin
				if (!free_found) begin
					res_d.status = ST_NO_ID;
				end else begin
					active_d[free_id] = 1'b1;
					for (int i = 0; i < SLOTS; i++) begin
						if (in_range[i]) begin
							pending_d[i][free_id] = 1'b1;
						end
					end
					rdidx_we       = 1'b1;
					rdidx_wa       = free_id;
					rdidx_wd       = oldest_q;
					res_d.given_id = ID_W'(free_id);
				end
			end
			OP_UNSUBSCRIBE: begin
				if (id_ok) begin
					active_d[id_r] = 1'b0;
					for (int i = 0; i < SLOTS; i++) begin
						pending_d[i][id_r] = 1'b0;
					end
				end
			end
			OP_WRITE: begin
				if (active_q == '0) begin
					res_d.status = ST_DROPPED;
				end else begin
					ram_we             = 1'b1;
					pending_d[end_idx] = active_q;
					if (count_q == CNT_W'(SLOTS)) begin
						res_d.status = ST_OVERWROTE;
					end else begin
						count_d = count_q + CNT_W'(1);
					end
				end
			end
			OP_READ: begin
				if (count_q == '0) begin
					res_d.status = ST_EMPTY;
				end else if (!id_ok || !pending_q[pos_q][id_r]) begin
					res_d.status = ST_NOT_PENDING;
				end else begin
					res_d.read_word  = ram_rdata;
					pending_d[pos_q] = pend_left;
					if (pend_left == '0) begin
						count_d  = count_q - CNT_W'(1);
						oldest_d = slot_add(oldest_q, CNT_W'(1));
					end
					rdidx_we = 1'b1;
					rdidx_wa = id_r;
					rdidx_wd = slot_add(pos_q, CNT_W'(1));
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
			oldest_q <= '0;
			count_q  <= '0;
			for (int i = 0; i < SLOTS; i++) begin
				pending_q[i] <= '0;
			end
			for (int r = 0; r < READERS; r++) begin
				rdidx_q[r] <= '0;
			end
		end else if (ctl.execute) begin
			active_q  <= active_d;
			oldest_q  <= oldest_d;
			count_q   <= count_d;
			pending_q <= pending_d;
			if (rdidx_we) begin
				rdidx_q[rdidx_wa] <= rdidx_wd;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			op_q   <= op_t'(cmd.op);
			id_q   <= cmd.subscriber;
			word_q <= cmd.write_word;
			pos_q  <= ram_raddr;
		end
		if (ctl.execute) begin
			res_q <= res_d;
		end
	end

	mrbr_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (SLOTS)
	) u_words (
		.clk   (clk),
		.we    (ram_we & ctl.execute),
		.waddr (end_idx),
		.wdata (word_q),
		.re    (ctl.capture),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign result = res_q;

	logic [READERS-1:0] pend_or;
	always_comb begin
		pend_or = '0;
		for (int i = 0; i < SLOTS; i++) begin
			pend_or = pend_or | pending_q[i];
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(SLOTS)) else $error("held count beyond ring size");

	a_pending_active: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_or & ~active_q) == '0) else $error("pending bit for inactive id");

	a_exec_after_capture: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.execute |-> $past(ctl.capture)) else $error("execute without item");

endmodule

>>> hw/rtl/multi_reader_broadcast_ring_unit.sv
// ----------------------------------------------------------------------------
// multi_reader_broadcast_ring_unit
// done strobes from a register fed by the execute state.
// A new item is not taken while one executes: the registered read of the
// slot word RAM is followed by the execute state, with busy high in it.
// Reset clears subscriptions, pending masks, pointers and the held count.
// Results cannot be stalled: each stays on result until the next execute.
// ----------------------------------------------------------------------------
module multi_reader_broadcast_ring_unit
	import mrbr_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  cmd_t    cmd,
	output logic    busy,
	output logic    done,
	output result_t result
);

	// Flow per item:
	//   idle cycle  - start accepted, command captured, RAM read of the
	//                 reader's slot launched, its pointer latched
	//   exec cycle  - op applied to masks, pointers and count; a write
	//                 lands in the RAM; result registered
	//   next cycle  - done pulses with result while a new item may be taken
	ctl_t ctl;

	mrbr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.ctl    (ctl)
	);

	// Datapath holds the ring: pending masks in flops (cleared on reset,
	// updated column-wise for subscribe/unsubscribe), words in RAM.
	mrbr_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.cmd    (cmd),
		.result (result)
	);

endmodule
